/* design/leb_pkg.sv */
// Shared types and constants for the LEB128 stream decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package leb_pkg;

	localparam int unsigned RESULT_W    = 64;
	localparam int unsigned PAYLOAD_W   = 7;
	localparam int unsigned COUNT_W     = 4;
	localparam int unsigned POS_W       = 7;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
	localparam logic [POS_W-1:0]   CHUNK     = 7'd7;

	typedef enum logic [0:0] {
		STATUS_OK        = 1'b0,
		STATUS_TRUNCATED = 1'b1
	} status_t;

	typedef enum logic [1:0] {
		KIND_CONT  = 2'd0,
		KIND_FINAL = 2'd1,
		KIND_TRUNC = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_signed;
		logic       stream_end;
	} byte_item_t;

	typedef struct packed {
		logic [RESULT_W-1:0] decoded_value;
		logic                status;
		logic [COUNT_W-1:0]  byte_count;
	} result_item_t;

	typedef struct packed {
		kind_t                kind;
		logic                 is_signed;
		logic [PAYLOAD_W-1:0] payload;
	} cmd_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_stat_t;

endpackage

`default_nettype wire

/* design/leb128_stream_decoder.sv */
// Top level of the LEB128 stream decoder: front end, command queue, back end.
// Depends on leb_pkg, leb_front, leb_queue and leb_back.
//
// Decodes unsigned or signed LEB128 one byte per transfer at a sustained rate of one
// byte per cycle unless result_stall holds a pending result; the back end's per-byte
// shift-and-OR into the 64-bit accumulator sets that rate. A value's result is loaded
// into the output register when its final byte is popped from the queue head; the pop
// waits while a stalled result holds the output register. A stream that ends on a byte
// with the continuation bit set yields a truncated result with value zero. Bits at or
// above VALUE_WIDTH are dropped; byte_count saturates at 15.
`default_nettype none

module leb128_stream_decoder #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   byte_valid,
	output logic                  byte_stall,
	input  leb_pkg::byte_item_t   byte_data,
	output logic                  result_valid,
	input  wire                   result_stall,
	output leb_pkg::result_item_t result_data
);
	import leb_pkg::*;

	queue_stat_t qstat;
	cmd_t        push_cmd;
	cmd_t        head;
	logic        push;
	logic        pop;

	leb_front u_front (
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.qstat      (qstat),
		.push       (push),
		.cmd        (push_cmd)
	);

	leb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	leb_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	a_trunc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.status == STATUS_TRUNCATED) |->
			(result_data.decoded_value == '0))
		else $error("truncated result carries a nonzero value");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.byte_count != '0))
		else $error("result with zero byte count");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.not_empty)
		else $error("pop from empty queue");

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && !byte_stall) |=> qstat.not_empty)
		else $error("accepted byte not held in queue");

endmodule

`default_nettype wire

/* design/leb_front.sv */
// Front end: accepts encoded bytes and classifies each as continue, final or truncated.
// Depends on leb_pkg; feeds leb_queue.
`default_nettype none

module leb_front (
	input  wire                 byte_valid,
	output logic                byte_stall,
	input  leb_pkg::byte_item_t byte_data,
	input  leb_pkg::queue_stat_t qstat,
	output logic                push,
	output leb_pkg::cmd_t       cmd
);
	import leb_pkg::*;

	assign byte_stall = qstat.full;
	assign push       = byte_valid && !qstat.full;

	always_comb begin
		cmd.payload   = byte_data.data_byte[PAYLOAD_W-1:0];
		cmd.is_signed = byte_data.is_signed;
		if (!byte_data.data_byte[7]) begin
			cmd.kind = KIND_FINAL;
		end else if (byte_data.stream_end) begin
			cmd.kind = KIND_TRUNC;
		end else begin
			cmd.kind = KIND_CONT;
		end
	end

endmodule

`default_nettype wire

/* design/leb_queue.sv */
// Short command queue between the front end and the back end.
// Depends on leb_pkg.
`default_nettype none

module leb_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  leb_pkg::cmd_t        push_cmd,
	input  wire                  pop,
	output leb_pkg::cmd_t        head,
	output leb_pkg::queue_stat_t qstat
);
	import leb_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head            = mem_q[rd_ptr_q];
	assign qstat.not_empty = (count_q != '0);
	assign qstat.full      = (count_q == FULL_CNT);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/leb_back.sv */
// Back end: accumulates payload chunks, sign-extends and registers each result.
// Depends on leb_pkg; drains leb_queue.
`default_nettype none

module leb_back #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  leb_pkg::cmd_t         head,
	input  leb_pkg::queue_stat_t  qstat,
	output logic                  pop,
	output logic                  result_valid,
	input  wire                   result_stall,
	output leb_pkg::result_item_t result_data
);
	import leb_pkg::*;

	localparam logic [RESULT_W-1:0] VMASK = (VALUE_WIDTH >= RESULT_W) ? '1 :
		((RESULT_W'(1) << VALUE_WIDTH) - RESULT_W'(1));
	localparam logic [POS_W-1:0] VW = POS_W'(VALUE_WIDTH);

	logic [RESULT_W-1:0] acc_q;
	logic [POS_W-1:0]    pos_q;
	logic [COUNT_W-1:0]  seen_q;
	logic                result_valid_q;
	result_item_t        result_q;

	logic                emits;
	logic                out_free;
	logic [RESULT_W-1:0] acc_n;
	logic [RESULT_W-1:0] final_val;
	logic [POS_W-1:0]    pos_n;
	logic [COUNT_W-1:0]  count_n;

	assign emits    = (head.kind != KIND_CONT);
	assign out_free = !result_valid_q || !result_stall;
	assign pop      = qstat.not_empty && (!emits || out_free);

	always_comb begin
		acc_n = acc_q;
		if (pos_q < VW) begin
			acc_n = acc_q | ({{(RESULT_W-PAYLOAD_W){1'b0}}, head.payload} << pos_q[5:0]);
		end
		acc_n   = acc_n & VMASK;
		pos_n   = (pos_q < VW) ? pos_q + CHUNK : pos_q;
		count_n = (seen_q < COUNT_MAX) ? seen_q + 1'b1 : COUNT_MAX;

		final_val = acc_n;
		if (head.is_signed && head.payload[6] && (pos_n < VW)) begin
			final_val = (acc_n | ({RESULT_W{1'b1}} << pos_n[5:0])) & VMASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			pos_q          <= '0;
			seen_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (emits) begin
					acc_q  <= '0;
					pos_q  <= '0;
					seen_q <= '0;
				end else begin
					acc_q  <= acc_n;
					pos_q  <= pos_n;
					seen_q <= count_n;
				end
			end
			if (out_free) begin
				result_valid_q <= pop && emits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			result_q.byte_count <= count_n;
			if (head.kind == KIND_TRUNC) begin
				result_q.decoded_value <= '0;
				result_q.status        <= STATUS_TRUNCATED;
			end else begin
				result_q.decoded_value <= final_val;
				result_q.status        <= STATUS_OK;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

`default_nettype wire
